>>> design/wpt_pkg.sv
package wpt_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int CRD_W = 32;
  localparam int COEF_W = 18;
  localparam int MAG_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ZOOM_W = 16;
  localparam int ANGLE_W = 16;
  localparam int NUM_AXES = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_X_BIAS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_BIAS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Z = 3'd5;

  localparam logic [ZOOM_W-1:0] ZOOM_RESET = 16'd256;

  typedef enum logic [1:0] {
    ACT_MOVE = 2'd0,
    ACT_ZOOM = 2'd1,
    ACT_ROTATE = 2'd2,
    ACT_PASS = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    TRIG_IDLE,
    TRIG_SIN,
    TRIG_COS,
    TRIG_FIN
  } trig_state_e;

  typedef struct packed {
    logic en;
    logic signed [COEF_W-1:0] cos_v;
    logic signed [COEF_W-1:0] sin_v;
  } coef_t;

  function automatic logic signed [CRD_W-1:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -51'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[CRD_W-1:0];
    end
  endfunction

endpackage

>>> design/wpt_if.sv
interface wpt_in_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic signed [31:0] x_in;
  logic signed [31:0] y_in;
  logic signed [31:0] z_in;
  logic last_point;

  modport source (output valid, action, x_in, y_in, z_in, last_point, input ready);
  modport sink (input valid, action, x_in, y_in, z_in, last_point, output ready);
endinterface

interface wpt_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  logic signed [31:0] z_out;
  logic last_out;

  modport source (output valid, x_out, y_out, z_out, last_out, input ready);
  modport sink (input valid, x_out, y_out, z_out, last_out, output ready);
endinterface

>>> design/wpt_trig.sv
module wpt_trig import wpt_pkg::*; #(
  parameter int SineDepth = SINE_TABLE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [NUM_AXES-1:0]       ang_we_i,
  input  logic [ANGLE_W-1:0]        ang_data_i,
  output logic                      busy_o,
  output coef_t [NUM_AXES-1:0]      coef_o
);

  localparam int AW = $clog2(SineDepth + 1);
  localparam int PW = 14 + AW + 1;

  typedef logic [MAG_W-1:0] tab_t [0:SineDepth];

  function automatic tab_t build_table();
    tab_t t;
    longint unsigned theta, sq, term, pr;
    longint signed sum, r;
    for (int i = 0; i <= SineDepth; i++) begin
      theta = (longint'(i) * 64'd1686629713) / SineDepth;
      sq = (theta * theta) >> 30;
      term = theta;
      sum = longint'(theta);
      for (int k = 1; k <= 7; k++) begin
        pr = term * sq;
        case (k)
          1:       term = pr / 64'd6;
          2:       term = pr / 64'd20;
          3:       term = pr / 64'd42;
          4:       term = pr / 64'd72;
          5:       term = pr / 64'd110;
          6:       term = pr / 64'd156;
          7:       term = pr / 64'd210;
          default: term = 64'd0;
        endcase
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 8192) >>> 14;
      if (r > 65536) begin
        r = 65536;
      end
      t[i] = r[MAG_W-1:0];
    end
    return t;
  endfunction

  localparam tab_t SineTable = build_table();

  trig_state_e state_q, state_d;
  logic [ANGLE_W-1:0] angle_q [NUM_AXES];
  logic [NUM_AXES-1:0] pend_q;
  logic [1:0] axis_q, pick;
  logic [ANGLE_W-1:0] cur_angle, rd_angle;
  logic [PW-1:0] prod;
  logic [AW-1:0] idx, addr;
  logic [MAG_W-1:0] rom_q;
  logic neg_q;
  logic signed [COEF_W-1:0] sin_q, rom_val;
  coef_t [NUM_AXES-1:0] coef_q;

  always_comb begin
    pick = 2'd0;
    for (int i = NUM_AXES - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        pick = 2'(i);
      end
    end
  end

  assign cur_angle = angle_q[axis_q];
  assign rd_angle = (state_q == TRIG_COS) ? cur_angle + 16'h4000 : cur_angle;
  assign prod = PW'(rd_angle[13:0]) * PW'(SineDepth);
  assign idx = prod[14 +: AW];
  assign addr = rd_angle[14] ? AW'(SineDepth) - idx : idx;
  assign rom_val = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  always_comb begin
    state_d = state_q;
    case (state_q)
      TRIG_IDLE: if (|pend_q) state_d = TRIG_SIN;
      TRIG_SIN:  state_d = TRIG_COS;
      TRIG_COS:  state_d = TRIG_FIN;
      TRIG_FIN:  state_d = TRIG_IDLE;
      default:   state_d = TRIG_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != TRIG_IDLE) || (|pend_q);
    coef_o = coef_q;
  end

  always_ff @(posedge clk_i) begin
    rom_q <= SineTable[addr];
    neg_q <= rd_angle[15];
    if (state_q == TRIG_COS) begin
      sin_q <= (axis_q == 2'd2) ? -rom_val : rom_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TRIG_IDLE;
      pend_q <= '0;
      axis_q <= '0;
      coef_q <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        angle_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == TRIG_IDLE && (|pend_q)) begin
        axis_q <= pick;
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        if (ang_we_i[i]) begin
          angle_q[i] <= ang_data_i;
          pend_q[i] <= 1'b1;
        end else if (state_q == TRIG_IDLE && pick == 2'(i)) begin
          pend_q[i] <= 1'b0;
        end
      end
      if (state_q == TRIG_FIN) begin
        coef_q[axis_q].en <= (cur_angle != '0);
        coef_q[axis_q].cos_v <= rom_val;
        coef_q[axis_q].sin_v <= sin_q;
      end
    end
  end

endmodule

>>> design/wpt_front.sv
module wpt_front import wpt_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       vld_i,
  input  action_e                    act_i,
  input  logic [2:0][CRD_W-1:0]      crd_i,
  input  logic                       last_i,
  input  logic signed [CRD_W-1:0]    x_bias_i,
  input  logic signed [CRD_W-1:0]    y_bias_i,
  input  logic [ZOOM_W-1:0]          zoom_i,
  output logic                       vld_o,
  output action_e                    act_o,
  output logic [2:0][CRD_W-1:0]      crd_o,
  output logic                       last_o
);

  logic v1_q, last1_q;
  action_e act1_q;
  logic signed [48:0] w1_d [3];
  logic signed [48:0] w1_q [3];
  logic signed [48:0] rnd [3];
  logic signed [CRD_W-1:0] bias [3];

  assign bias[0] = x_bias_i;
  assign bias[1] = y_bias_i;
  assign bias[2] = '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (act_i)
        ACT_MOVE: w1_d[i] = 49'($signed(crd_i[i])) + 49'(bias[i]);
        ACT_ZOOM: w1_d[i] = 49'($signed(crd_i[i])) * 49'($signed({1'b0, zoom_i}));
        default:  w1_d[i] = 49'($signed(crd_i[i]));
      endcase
      rnd[i] = (w1_q[i] + 49'sd128) >>> 8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vld_o <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
      vld_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      act1_q <= act_i;
      last1_q <= last_i;
      act_o <= act1_q;
      last_o <= last1_q;
      for (int i = 0; i < 3; i++) begin
        w1_q[i] <= w1_d[i];
        crd_o[i] <= (act1_q == ACT_ZOOM) ? sat32(51'(rnd[i])) : sat32(51'(w1_q[i]));
      end
    end
  end

endmodule

>>> design/wpt_rot.sv
module wpt_rot import wpt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      vld_i,
  input  logic                      rot_i,
  input  coef_t                     coef_i,
  input  logic signed [CRD_W-1:0]   a_i,
  input  logic signed [CRD_W-1:0]   b_i,
  input  logic signed [CRD_W-1:0]   o_i,
  input  logic                      last_i,
  output logic                      vld_o,
  output logic                      rot_o,
  output logic signed [CRD_W-1:0]   a_o,
  output logic signed [CRD_W-1:0]   b_o,
  output logic signed [CRD_W-1:0]   o_o,
  output logic                      last_o
);

  logic v1_q, rot1_q, en1_q, last1_q;
  logic signed [CRD_W-1:0] a1_q, b1_q, o1_q;
  logic signed [49:0] p_ac_q, p_bs_q, p_as_q, p_bc_q;
  logic signed [50:0] sum_a, sum_b;

  assign sum_a = (51'(p_ac_q) + 51'(p_bs_q) + 51'sd32768) >>> 16;
  assign sum_b = (51'(p_bc_q) - 51'(p_as_q) + 51'sd32768) >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vld_o <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
      vld_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rot1_q <= rot_i;
      en1_q <= rot_i && coef_i.en;
      last1_q <= last_i;
      a1_q <= a_i;
      b1_q <= b_i;
      o1_q <= o_i;
      p_ac_q <= 50'(a_i) * 50'(coef_i.cos_v);
      p_bs_q <= 50'(b_i) * 50'(coef_i.sin_v);
      p_as_q <= 50'(a_i) * 50'(coef_i.sin_v);
      p_bc_q <= 50'(b_i) * 50'(coef_i.cos_v);
      rot_o <= rot1_q;
      last_o <= last1_q;
      o_o <= o1_q;
      a_o <= en1_q ? sat32(sum_a) : a1_q;
      b_o <= en1_q ? sat32(sum_b) : b1_q;
    end
  end

endmodule

>>> design/wireframe_point_transform_unit.sv
// Each accepted input beat passes the front, X, Y and Z rotation pipelines.
// Throughput: one point per cycle while no angle update is in progress; a stall
// at the output freezes every stage. Sine and cosine are looked up after an
// angle write; input is held off while the coefficients settle.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and sets
// biases and angles to zero and zoom to 1.0.
module wireframe_point_transform_unit import wpt_pkg::*; #(
  parameter int SineDepth = SINE_TABLE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  wpt_in_if.sink                 in_s,
  wpt_out_if.source              out_s,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic adv, busy, in_fire;
  logic signed [CRD_W-1:0] x_bias_q, y_bias_q;
  logic [ZOOM_W-1:0] zoom_q;
  logic [NUM_AXES-1:0] ang_we;
  coef_t [NUM_AXES-1:0] coef;

  logic f_vld, f_last;
  action_e f_act;
  logic [2:0][CRD_W-1:0] f_crd;

  logic x_vld, x_rot, x_last, y_vld, y_rot, y_last;
  logic signed [CRD_W-1:0] x_a, x_b, x_o, y_a, y_b, y_o;

  assign adv = !out_s.valid || out_s.ready;
  assign in_s.ready = adv && !busy;
  assign in_fire = in_s.valid && in_s.ready;

  assign ang_we[0] = cfg_we_i && (cfg_idx_i == CFG_ANGLE_X);
  assign ang_we[1] = cfg_we_i && (cfg_idx_i == CFG_ANGLE_Y);
  assign ang_we[2] = cfg_we_i && (cfg_idx_i == CFG_ANGLE_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_bias_q <= '0;
      y_bias_q <= '0;
      zoom_q <= ZOOM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_BIAS: x_bias_q <= cfg_data_i;
        CFG_Y_BIAS: y_bias_q <= cfg_data_i;
        CFG_ZOOM:   zoom_q <= cfg_data_i[ZOOM_W-1:0];
        default:    ;
      endcase
    end
  end

  wpt_trig #(.SineDepth(SineDepth)) u_trig (
    .clk_i, .rst_ni,
    .ang_we_i   (ang_we),
    .ang_data_i (cfg_data_i[ANGLE_W-1:0]),
    .busy_o     (busy),
    .coef_o     (coef)
  );

  wpt_front u_front (
    .clk_i, .rst_ni,
    .adv_i    (adv),
    .vld_i    (in_fire),
    .act_i    (action_e'(in_s.action)),
    .crd_i    ({in_s.z_in, in_s.y_in, in_s.x_in}),
    .last_i   (in_s.last_point),
    .x_bias_i (x_bias_q),
    .y_bias_i (y_bias_q),
    .zoom_i   (zoom_q),
    .vld_o    (f_vld),
    .act_o    (f_act),
    .crd_o    (f_crd),
    .last_o   (f_last)
  );

  wpt_rot u_rot_x (
    .clk_i, .rst_ni,
    .adv_i (adv), .vld_i (f_vld), .rot_i (f_act == ACT_ROTATE), .coef_i (coef[0]),
    .a_i ($signed(f_crd[1])), .b_i ($signed(f_crd[2])), .o_i ($signed(f_crd[0])),
    .last_i (f_last),
    .vld_o (x_vld), .rot_o (x_rot), .a_o (x_a), .b_o (x_b), .o_o (x_o),
    .last_o (x_last)
  );

  wpt_rot u_rot_y (
    .clk_i, .rst_ni,
    .adv_i (adv), .vld_i (x_vld), .rot_i (x_rot), .coef_i (coef[1]),
    .a_i (x_o), .b_i (x_b), .o_i (x_a),
    .last_i (x_last),
    .vld_o (y_vld), .rot_o (y_rot), .a_o (y_a), .b_o (y_b), .o_o (y_o),
    .last_o (y_last)
  );

  wpt_rot u_rot_z (
    .clk_i, .rst_ni,
    .adv_i (adv), .vld_i (y_vld), .rot_i (y_rot), .coef_i (coef[2]),
    .a_i (y_a), .b_i (y_o), .o_i (y_b),
    .last_i (y_last),
    .vld_o (out_s.valid), .rot_o (), .a_o (out_s.x_out), .b_o (out_s.y_out),
    .o_o (out_s.z_out),
    .last_o (out_s.last_out)
  );

endmodule

>>> design/wpt_checker.sv
module wpt_checker import wpt_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [31:0]           x_out_i,
  input logic [31:0]           y_out_i,
  input logic [31:0]           z_out_i,
  input logic                  last_out_i,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(x_out_i) && $stable(y_out_i) &&
      $stable(z_out_i) && $stable(last_out_i))
    else $error("output beat changed while stalled");

  a_ready_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("input taken while pipeline frozen");

  a_angle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == CFG_ANGLE_X || cfg_idx_i == CFG_ANGLE_Y ||
      cfg_idx_i == CFG_ANGLE_Z) |=> !in_ready_i)
    else $error("input taken before coefficients settled");

endmodule

bind wireframe_point_transform_unit wpt_checker u_wpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_s.valid),
  .in_ready_i  (in_s.ready),
  .out_valid_i (out_s.valid),
  .out_ready_i (out_s.ready),
  .x_out_i     (out_s.x_out),
  .y_out_i     (out_s.y_out),
  .z_out_i     (out_s.z_out),
  .last_out_i  (out_s.last_out),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i)
);
